[sv/gms_pkg.sv]
package gms_pkg;

	// Gate modes, as reported on the result word
	typedef enum logic [2:0] {
		MODE_NORMAL   = 3'd0,
		MODE_DETECTED = 3'd1,
		MODE_SLEEP    = 3'd2,
		MODE_READY    = 3'd3,
		MODE_EMPTY    = 3'd4
	} gate_mode_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_LOW_ADC_LIMIT  = 3'd0,
		CFG_LOW_RUN_LIMIT  = 3'd1,
		CFG_NEAR_HALF_MAX  = 3'd2,
		CFG_DETECT_HALF_MIN = 3'd3,
		CFG_DETECT_HOLD    = 3'd4,
		CFG_IDLE_TIMEOUT   = 3'd5,
		CFG_FAIL_LIMIT     = 3'd6
	} cfg_index_t;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;

	// Saturation points of the counters
	localparam logic [7:0] MISS_MAX    = 8'hFF;
	localparam logic [9:0] LOW_RUN_MAX = 10'h3FF;

	// Reset values of the configuration registers
	localparam logic [7:0]  RST_LOW_ADC_LIMIT   = 8'd215;
	localparam logic [9:0]  RST_LOW_RUN_LIMIT   = 10'd150;
	localparam logic [13:0] RST_NEAR_HALF_MAX   = 14'd1746;
	localparam logic [13:0] RST_DETECT_HALF_MIN = 14'd30;
	localparam logic [15:0] RST_DETECT_HOLD     = 16'd3000;
	localparam logic [31:0] RST_IDLE_TIMEOUT    = 32'd300000;
	localparam logic [7:0]  RST_FAIL_LIMIT      = 8'd10;

	typedef struct packed {
		logic [7:0]  low_battery_adc_limit;
		logic [9:0]  low_battery_run_limit;
		logic [13:0] near_half_echo_max;
		logic [13:0] detect_half_echo_min;
		logic [15:0] detect_hold_ms;
		logic [31:0] idle_timeout_ms;
		logic [7:0]  sensor_fail_limit;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [7:0]  adc_code;
		logic [14:0] echo_us;
		logic        sleep_request;
	} poll_word_t;

	typedef struct packed {
		gate_mode_t  mode;
		logic        hold_active;
		logic [31:0] hold_start;
		logic [31:0] last_near_time;
		logic [7:0]  miss_count;
		logic [9:0]  low_run_count;
		logic        empty_flag;
	} sup_state_t;

	typedef struct packed {
		gate_mode_t gate_mode;
		logic       mode_changed;
		logic       battery_empty;
		logic       sensor_failed;
	} status_word_t;

endpackage

[sv/gms_if.sv]
// Polling pass channel
interface gms_poll_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [7:0]  adc_code;
	logic [14:0] echo_us;
	logic        sleep_request;

	modport source (output valid, output now_ms, output adc_code, output echo_us,
		output sleep_request, input ready);
	modport sink (input valid, input now_ms, input adc_code, input echo_us,
		input sleep_request, output ready);
endinterface

// Status result channel
interface gms_status_if;
	logic       valid;
	logic       ready;
	logic [2:0] gate_mode;
	logic       mode_changed;
	logic       battery_empty;
	logic       sensor_failed;

	modport source (output valid, output gate_mode, output mode_changed,
		output battery_empty, output sensor_failed, input ready);
	modport sink (input valid, input gate_mode, input mode_changed,
		input battery_empty, input sensor_failed, output ready);
endinterface

[sv/gms_cfg_regs.sv]
module gms_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gms_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output gms_pkg::cfg_t                    cfg
);

	// Register file; writes beyond the list are dropped, data masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.low_battery_adc_limit <= gms_pkg::RST_LOW_ADC_LIMIT;
			cfg.low_battery_run_limit <= gms_pkg::RST_LOW_RUN_LIMIT;
			cfg.near_half_echo_max    <= gms_pkg::RST_NEAR_HALF_MAX;
			cfg.detect_half_echo_min  <= gms_pkg::RST_DETECT_HALF_MIN;
			cfg.detect_hold_ms        <= gms_pkg::RST_DETECT_HOLD;
			cfg.idle_timeout_ms       <= gms_pkg::RST_IDLE_TIMEOUT;
			cfg.sensor_fail_limit     <= gms_pkg::RST_FAIL_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				gms_pkg::CFG_LOW_ADC_LIMIT:   cfg.low_battery_adc_limit <= cfg_wdata[7:0];
				gms_pkg::CFG_LOW_RUN_LIMIT:   cfg.low_battery_run_limit <= cfg_wdata[9:0];
				gms_pkg::CFG_NEAR_HALF_MAX:   cfg.near_half_echo_max    <= cfg_wdata[13:0];
				gms_pkg::CFG_DETECT_HALF_MIN: cfg.detect_half_echo_min  <= cfg_wdata[13:0];
				gms_pkg::CFG_DETECT_HOLD:     cfg.detect_hold_ms        <= cfg_wdata[15:0];
				gms_pkg::CFG_IDLE_TIMEOUT:    cfg.idle_timeout_ms       <= cfg_wdata[31:0];
				gms_pkg::CFG_FAIL_LIMIT:      cfg.sensor_fail_limit     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

endmodule

[sv/gms_eval.sv]
module gms_eval (
	input  gms_pkg::cfg_t         cfg,
	input  gms_pkg::poll_word_t   word,
	input  gms_pkg::sup_state_t   state,
	output gms_pkg::sup_state_t   state_next,
	output gms_pkg::status_word_t status
);

	logic [13:0]         half;
	logic                near;
	logic                detect;
	logic [7:0]          miss_new;
	logic [31:0]         last_near_new;
	logic [31:0]         hold_elapsed;
	logic [31:0]         idle_elapsed;
	logic                evaluate;
	logic                low;
	logic [9:0]          low_run_new;
	logic                empty_new;
	gms_pkg::gate_mode_t next_mode;
	logic                changed;

	// Echo judgement, every pass
	assign half          = word.echo_us[14:1];
	assign near          = (half != 14'd0) && (half <= cfg.near_half_echo_max);
	assign detect        = near && (half >= cfg.detect_half_echo_min);
	assign miss_new      = (half != 14'd0) ? 8'd0 :
		(state.miss_count == gms_pkg::MISS_MAX) ? gms_pkg::MISS_MAX : state.miss_count + 8'd1;
	assign last_near_new = near ? word.now_ms : state.last_near_time;

	// Hold check, modulo 2^32 elapsed time
	assign hold_elapsed = word.now_ms - state.hold_start;
	assign evaluate     = !state.hold_active || (hold_elapsed >= {16'd0, cfg.detect_hold_ms});

	// Low battery run
	assign low         = word.adc_code <= cfg.low_battery_adc_limit;
	assign low_run_new = !low ? 10'd0 :
		(state.low_run_count == gms_pkg::LOW_RUN_MAX) ? gms_pkg::LOW_RUN_MAX :
		state.low_run_count + 10'd1;
	assign empty_new   = state.empty_flag || (low && (low_run_new >= cfg.low_battery_run_limit));

	// Mode priority chain
	assign idle_elapsed = word.now_ms - last_near_new;
	always_comb begin
		if (empty_new)
			next_mode = gms_pkg::MODE_EMPTY;
		else if (word.sleep_request)
			next_mode = gms_pkg::MODE_SLEEP;
		else if (detect)
			next_mode = gms_pkg::MODE_DETECTED;
		else if ((idle_elapsed >= cfg.idle_timeout_ms) && (miss_new < cfg.sensor_fail_limit))
			next_mode = gms_pkg::MODE_READY;
		else
			next_mode = gms_pkg::MODE_NORMAL;
	end

	assign changed = evaluate && (next_mode != state.mode);

	// Next state
	always_comb begin
		state_next                = state;
		state_next.miss_count     = miss_new;
		state_next.last_near_time = last_near_new;
		if (evaluate) begin
			state_next.low_run_count = low_run_new;
			state_next.empty_flag    = empty_new;
		end
		if (changed) begin
			state_next.mode        = next_mode;
			state_next.hold_start  = word.now_ms;
			state_next.hold_active = (next_mode == gms_pkg::MODE_DETECTED);
		end
	end

	// Result word
	assign status.gate_mode     = state_next.mode;
	assign status.mode_changed  = changed;
	assign status.battery_empty = state_next.empty_flag;
	assign status.sensor_failed = miss_new >= cfg.sensor_fail_limit;

endmodule

[sv/gate_mode_supervisor.sv]
// Channel   Role    Word
// poll      sink    now_ms[31:0], adc_code[7:0], echo_us[14:0], sleep_request
// status    source  gate_mode[2:0], mode_changed, battery_empty, sensor_failed
// cfg       write   cfg_we, cfg_index[2:0], cfg_wdata[31:0]
//
// Two registers: poll input register, then evaluation into the status register.
// One word per cycle while status is not stalled; the supervisor state updates as a word leaves the
// input register, so consecutive passes see each other's effect in order.
// arst_n clears the supervisor state, both valid flags and loads register defaults.
// A stalled status register holds its word and the input register; poll.ready
// stays high while the input register is empty or moving on.
module gate_mode_supervisor (
	input  logic                           clk,
	input  logic                           arst_n,
	gms_poll_if.sink                       poll,
	gms_status_if.source                   status,
	input  logic                           cfg_we,
	input  logic [gms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gms_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	gms_pkg::cfg_t         cfg;
	gms_pkg::poll_word_t   word_s1;
	logic                  valid_s1;
	gms_pkg::sup_state_t   state_q;
	gms_pkg::sup_state_t   state_next;
	gms_pkg::status_word_t result;
	gms_pkg::status_word_t result_s2;
	logic                  valid_s2;
	logic                  advance;

	gms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gms_eval u_eval (
		.cfg        (cfg),
		.word       (word_s1),
		.state      (state_q),
		.state_next (state_next),
		.status     (result)
	);

	// Handshake control
	assign advance    = valid_s1 && (!valid_s2 || status.ready);
	assign poll.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.valid && poll.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			word_s1.now_ms        <= poll.now_ms;
			word_s1.adc_code      <= poll.adc_code;
			word_s1.echo_us       <= poll.echo_us;
			word_s1.sleep_request <= poll.sleep_request;
		end
	end

	// Supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= gms_pkg::MODE_NORMAL;
			state_q.hold_active    <= 1'b0;
			state_q.hold_start     <= 32'd0;
			state_q.last_near_time <= 32'd0;
			state_q.miss_count     <= 8'd0;
			state_q.low_run_count  <= 10'd0;
			state_q.empty_flag     <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (status.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign status.valid         = valid_s2;
	assign status.gate_mode     = result_s2.gate_mode;
	assign status.mode_changed  = result_s2.mode_changed;
	assign status.battery_empty = result_s2.battery_empty;
	assign status.sensor_failed = result_s2.sensor_failed;

endmodule
